// ===== src/uydtm_pkg.sv =====
// Shared types, configuration indexes and the tone table for the UYVY decimator.
package uydtm_pkg;

  localparam int unsigned CfgWidth = 12;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_STEP_X    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_STEP_Y    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_OUT_PAIRS = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_OUT_ROWS  = 2'd3;

  typedef struct packed {
    logic [1:0]  step_x;
    logic [1:0]  step_y;
    logic [10:0] out_pairs;
    logic [11:0] out_rows;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] u;
    logic [7:0] ya;
    logic [7:0] v;
    logic [7:0] yb;
    logic       row_last;
    logic       frame_last;
  } pair_t;

  localparam logic [7:0] TONE_ROM [256] = '{
    8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,8'h03,8'h03,8'h03,
    8'h04,8'h04,8'h04,8'h04,8'h05,8'h05,8'h05,8'h05,8'h06,8'h06,8'h06,8'h06,8'h07,8'h07,8'h07,8'h07,
    8'h08,8'h08,8'h08,8'h08,8'h09,8'h09,8'h09,8'h09,8'h0A,8'h0A,8'h0A,8'h0A,8'h0B,8'h0B,8'h0B,8'h0B,
    8'h0C,8'h0C,8'h0C,8'h0C,8'h0D,8'h0D,8'h0D,8'h0D,8'h0E,8'h0E,8'h0E,8'h0E,8'h0F,8'h0F,8'h0F,8'h0F,
    8'h10,8'h10,8'h10,8'h10,8'h11,8'h11,8'h11,8'h11,8'h12,8'h12,8'h12,8'h12,8'h13,8'h13,8'h13,8'h14,
    8'h14,8'h14,8'h14,8'h14,8'h15,8'h15,8'h16,8'h16,8'h16,8'h17,8'h17,8'h17,8'h18,8'h18,8'h18,8'h19,
    8'h19,8'h19,8'h1A,8'h1A,8'h1A,8'h1B,8'h1B,8'h1C,8'h1C,8'h1C,8'h1D,8'h1D,8'h1E,8'h1E,8'h1F,8'h1F,
    8'h20,8'h20,8'h21,8'h21,8'h22,8'h22,8'h23,8'h23,8'h24,8'h24,8'h25,8'h25,8'h26,8'h26,8'h27,8'h27,
    8'h28,8'h28,8'h29,8'h29,8'h2A,8'h2B,8'h2C,8'h2C,8'h2D,8'h2E,8'h2E,8'h2F,8'h30,8'h30,8'h31,8'h31,
    8'h32,8'h33,8'h34,8'h34,8'h35,8'h36,8'h37,8'h37,8'h38,8'h39,8'h3A,8'h3B,8'h3C,8'h3D,8'h3D,8'h3E,
    8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,
    8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h5A,8'h5C,8'h5D,8'h5F,8'h60,8'h61,8'h63,
    8'h64,8'h66,8'h67,8'h69,8'h6A,8'h6B,8'h6D,8'h6F,8'h70,8'h72,8'h74,8'h75,8'h77,8'h79,8'h7A,8'h7C,
    8'h7E,8'h80,8'h82,8'h84,8'h86,8'h88,8'h8A,8'h8B,8'h8D,8'h90,8'h92,8'h94,8'h96,8'h98,8'h9A,8'h9B,
    8'h9F,8'hA1,8'hA3,8'hA6,8'hA8,8'hAB,8'hAD,8'hB0,8'hB2,8'hB5,8'hB7,8'hBA,8'hBD,8'hC0,8'hC2,8'hC5,
    8'hC8,8'hCB,8'hCE,8'hD1,8'hD4,8'hD6,8'hDA,8'hDD,8'hE0,8'hE3,8'hE6,8'hE9,8'hEC,8'hF0,8'hF4,8'hFA
  };

endpackage

// ===== src/uydtm_ctrl.sv =====
// Line, row and pair counters with the pending half-pair store that select the kept bytes.
module uydtm_ctrl
  import uydtm_pkg::*;
#(
  parameter int unsigned MaxLineMacropixels = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       adv_i,
  input  logic [7:0] u_i,
  input  logic [7:0] y0_i,
  input  logic [7:0] v_i,
  input  logic [7:0] y1_i,
  input  logic       line_end_i,
  input  logic       frame_start_i,
  output pair_t      pair_o
);

  localparam int unsigned ColWidth = $clog2(MaxLineMacropixels + 1);
  localparam logic [ColWidth-1:0] ColMax = ColWidth'(MaxLineMacropixels);

  logic [ColWidth-1:0] col_q, col_d, col_eff;
  logic [11:0] row_q, row_d, row_eff;
  logic [10:0] pair_q, pair_d, pair_eff;
  logic [11:0] rcnt_q, rcnt_d, rcnt_eff;
  logic [23:0] held_q;

  logic [11:0] ymask;
  logic [3:0]  period;
  logic [2:0]  phase;
  logic        row_kept, col_ok, active, sx0, store, emit;

  always_comb begin
    col_eff  = frame_start_i ? '0 : col_q;
    row_eff  = frame_start_i ? '0 : row_q;
    pair_eff = frame_start_i ? '0 : pair_q;
    rcnt_eff = frame_start_i ? '0 : rcnt_q;

    ymask    = (12'd1 << cfg_i.step_y) - 12'd1;
    row_kept = ((row_eff & ymask) == 12'd0) && (rcnt_eff < cfg_i.out_rows);
    col_ok   = col_eff < ColMax;
    active   = row_kept && col_ok && (pair_eff < cfg_i.out_pairs);

    period = 4'd1 << cfg_i.step_x;
    phase  = col_eff[2:0] & 3'(period - 4'd1);
    sx0    = cfg_i.step_x == 2'd0;
    store  = active && !sx0 && (phase == 3'd0);
    emit   = active && (sx0 || (phase == period[3:1]));

    pair_o.emit       = emit;
    pair_o.u          = sx0 ? u_i  : held_q[23:16];
    pair_o.ya         = sx0 ? y0_i : held_q[15:8];
    pair_o.v          = sx0 ? v_i  : held_q[7:0];
    pair_o.yb         = sx0 ? y1_i : y0_i;
    pair_o.row_last   = ({1'b0, pair_eff} + 12'd1) == {1'b0, cfg_i.out_pairs};
    pair_o.frame_last = pair_o.row_last &&
                        (({1'b0, rcnt_eff} + 13'd1) == {1'b0, cfg_i.out_rows});

    if (line_end_i) begin
      col_d  = '0;
      pair_d = '0;
      row_d  = row_eff + 12'd1;
      rcnt_d = row_kept ? rcnt_eff + 12'd1 : rcnt_eff;
    end else begin
      col_d  = col_ok ? col_eff + ColWidth'(1) : col_eff;
      pair_d = emit ? pair_eff + 11'd1 : pair_eff;
      row_d  = row_eff;
      rcnt_d = rcnt_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pair_q <= '0;
      rcnt_q <= '0;
    end else if (adv_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pair_q <= pair_d;
      rcnt_q <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && store) begin
      held_q <= {u_i, y0_i, v_i};
    end
  end

endmodule

// ===== src/uydtm_tone.sv =====
// Tone table lookup applied to all four bytes of a selected pair.
module uydtm_tone
  import uydtm_pkg::*;
(
  input  pair_t pair_i,
  output pair_t pair_o
);

  always_comb begin
    pair_o    = pair_i;
    pair_o.u  = TONE_ROM[pair_i.u];
    pair_o.ya = TONE_ROM[pair_i.ya];
    pair_o.v  = TONE_ROM[pair_i.v];
    pair_o.yb = TONE_ROM[pair_i.yb];
  end

endmodule

// ===== src/uydtm_core.sv =====
// Top level of the UYVY decimator with tone mapping: input and result registers.
// Input words are held in the input register, result words in the result register.
// Throughput: one input word per cycle, set by the single registered selection stage,
// while the output does not stall. Each input word gives zero or one result word.
// Reset clears the counters, valid flags and configuration; no clearing pass is needed.
module uyvy_decimate_tone_map_core
  import uydtm_pkg::*;
#(
  parameter int unsigned MAX_LINE_MACROPIXELS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_u_i,
  input  logic [7:0]             in_y0_i,
  input  logic [7:0]             in_v_i,
  input  logic [7:0]             in_y1_i,
  input  logic                   line_end_i,
  input  logic                   frame_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_u_o,
  output logic [7:0]             out_ya_o,
  output logic [7:0]             out_v_o,
  output logic [7:0]             out_yb_o,
  output logic                   row_last_o,
  output logic                   frame_last_o
);

  cfg_t cfg_q;

  logic       s1_valid_q, s1_adv;
  logic [7:0] s1_u_q, s1_y0_q, s1_v_q, s1_y1_q;
  logic       s1_eol_q, s1_sof_q;

  pair_t raw_pair, mapped_pair, out_q;
  logic  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_X:    cfg_q.step_x    <= cfg_data_i[1:0];
        CFG_STEP_Y:    cfg_q.step_y    <= cfg_data_i[1:0];
        CFG_OUT_PAIRS: cfg_q.out_pairs <= cfg_data_i[10:0];
        CFG_OUT_ROWS:  cfg_q.out_rows  <= cfg_data_i[11:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_u_q   <= in_u_i;
      s1_y0_q  <= in_y0_i;
      s1_v_q   <= in_v_i;
      s1_y1_q  <= in_y1_i;
      s1_eol_q <= line_end_i;
      s1_sof_q <= frame_start_i;
    end
  end

  uydtm_ctrl #(
    .MaxLineMacropixels(MAX_LINE_MACROPIXELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .adv_i        (s1_adv),
    .u_i          (s1_u_q),
    .y0_i         (s1_y0_q),
    .v_i          (s1_v_q),
    .y1_i         (s1_y1_q),
    .line_end_i   (s1_eol_q),
    .frame_start_i(s1_sof_q),
    .pair_o       (raw_pair)
  );

  uydtm_tone u_tone (
    .pair_i(raw_pair),
    .pair_o(mapped_pair)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= raw_pair.emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && raw_pair.emit) begin
      out_q <= mapped_pair;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_u_o      = out_q.u;
  assign out_ya_o     = out_q.ya;
  assign out_v_o      = out_q.v;
  assign out_yb_o     = out_q.yb;
  assign row_last_o   = out_q.row_last;
  assign frame_last_o = out_q.frame_last;

endmodule
